// ===== src/pte_pkg.sv =====
// ----------------------------------------------------------------------------
// pte_pkg
// shared types and constants of the packet header tuple extractor
// ----------------------------------------------------------------------------
package pte_pkg;

    // header bytes kept per packet, later bytes are only counted
    localparam int          MAX_HDR_BYTES = 128;
    localparam logic [7:0]  HDR_LIMIT     = 8'(MAX_HDR_BYTES);
    localparam logic [7:0]  COUNT_MAX     = 8'hFF;

    // link types
    localparam logic [1:0]  LINK_ETHERNET = 2'd0;
    localparam logic [1:0]  LINK_NULL     = 2'd1;
    localparam logic [1:0]  LINK_RAW      = 2'd2;

    // start of the ip header per link framing
    localparam logic [4:0]  ETH_L3_OFFSET  = 5'd14;
    localparam logic [4:0]  VLAN_L3_OFFSET = 5'd18;
    localparam logic [4:0]  NULL_L3_OFFSET = 5'd4;
    localparam logic [4:0]  RAW_L3_OFFSET  = 5'd0;

    // ethernet byte positions
    localparam logic [7:0]  ETH_TYPE_HI    = 8'd12;
    localparam logic [7:0]  ETH_TYPE_LO    = 8'd13;
    localparam logic [7:0]  VLAN_TYPE_HI   = 8'd16;
    localparam logic [7:0]  VLAN_TYPE_LO   = 8'd17;
    localparam logic [7:0]  ETH_HDR_LEN    = 8'd14;

    localparam logic [15:0] ETHERTYPE_VLAN = 16'h8100;
    localparam logic [15:0] ETHERTYPE_IPV4 = 16'h0800;
    localparam logic [15:0] ETHERTYPE_IPV6 = 16'h86DD;

    // ip header layout
    localparam logic [3:0]  IP_VER4        = 4'd4;
    localparam logic [3:0]  IP_VER6        = 4'd6;
    localparam logic [7:0]  IPV4_MIN_HDR   = 8'd20;
    localparam logic [7:0]  IPV6_HDR_LEN   = 8'd40;
    localparam logic [7:0]  IPV4_PROTO_POS = 8'd9;
    localparam logic [7:0]  IPV4_SRC_POS   = 8'd12;
    localparam logic [7:0]  IPV4_DST_POS   = 8'd16;
    localparam logic [7:0]  IPV4_ADDR_END  = 8'd20;
    localparam logic [7:0]  IPV6_NEXT_POS  = 8'd6;
    localparam logic [7:0]  IPV6_SRC_POS   = 8'd8;
    localparam logic [7:0]  IPV6_DST_POS   = 8'd24;
    localparam logic [7:0]  IPV6_ADDR_END  = 8'd40;

    // transport layout
    localparam logic [7:0]  PORT_BYTES     = 8'd4;
    localparam logic [7:0]  TCP_FLAGS_POS  = 8'd13;
    localparam logic [7:0]  TCP_FLAGS_END  = 8'd14;
    localparam logic [7:0]  PROTO_TCP      = 8'd6;
    localparam logic [7:0]  PROTO_UDP      = 8'd17;
    localparam logic [7:0]  TCP_FLAG_SYN   = 8'h02;
    localparam logic [7:0]  TCP_FLAG_ACK   = 8'h10;

    typedef enum logic [2:0] {
        ST_OK      = 3'd0,
        ST_SHORT   = 3'd1,
        ST_NOT_IP  = 3'd2,
        ST_BAD_VER = 3'd3,
        ST_BAD_IHL = 3'd4
    } status_t;

    // one registered byte item
    typedef struct packed {
        logic       valid;
        logic       last;
        logic [7:0] data;
    } byte_item_t;

    // per packet capture state
    typedef struct packed {
        logic [7:0]   byte_count;
        logic [15:0]  ether_type;
        logic [4:0]   l3_offset;
        logic [7:0]   version_ihl;
        logic [7:0]   proto_byte;
        logic [127:0] src_addr;
        logic [127:0] dst_addr;
        logic [15:0]  src_port;
        logic [15:0]  dst_port;
        logic [7:0]   tcp_flags;
    } hdr_t;

    // one result item
    typedef struct packed {
        status_t      status;
        logic [2:0]   ip_version;
        logic [7:0]   ip_protocol;
        logic [63:0]  src_addr_high;
        logic [63:0]  src_addr_low;
        logic [63:0]  dst_addr_high;
        logic [63:0]  dst_addr_low;
        logic [15:0]  src_port;
        logic [15:0]  dst_port;
        logic         pure_syn;
        logic [7:0]   captured_length;
    } tuple_t;

endpackage

// ===== src/pte_byte_if.sv =====
// ----------------------------------------------------------------------------
// pte_byte_if
// packet byte channel, one byte per item with a last marker
// ----------------------------------------------------------------------------
interface pte_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] pkt_byte;
    logic       last;

    modport source (output valid, output pkt_byte, output last, input ready);
    modport sink   (input valid, input pkt_byte, input last, output ready);
endinterface

// ===== src/pte_tuple_if.sv =====
// ----------------------------------------------------------------------------
// pte_tuple_if
// result channel, one flow tuple or drop status per item
// ----------------------------------------------------------------------------
interface pte_tuple_if;
    logic        valid;
    logic        ready;
    logic [2:0]  status;
    logic [2:0]  ip_version;
    logic [7:0]  ip_protocol;
    logic [63:0] src_addr_high;
    logic [63:0] src_addr_low;
    logic [63:0] dst_addr_high;
    logic [63:0] dst_addr_low;
    logic [15:0] src_port;
    logic [15:0] dst_port;
    logic        pure_syn;
    logic [7:0]  captured_length;

    modport source (
        output valid, output status, output ip_version, output ip_protocol,
        output src_addr_high, output src_addr_low, output dst_addr_high,
        output dst_addr_low, output src_port, output dst_port, output pure_syn,
        output captured_length, input ready
    );
    modport sink (
        input valid, input status, input ip_version, input ip_protocol,
        input src_addr_high, input src_addr_low, input dst_addr_high,
        input dst_addr_low, input src_port, input dst_port, input pure_syn,
        input captured_length, output ready
    );
endinterface

// ===== src/pte_cfg_if.sv =====
// ----------------------------------------------------------------------------
// pte_cfg_if
// configuration write channel for the link type register
// ----------------------------------------------------------------------------
interface pte_cfg_if;
    logic       valid;
    logic       ready;
    logic [1:0] link_type;

    modport source (output valid, output link_type, input ready);
    modport sink   (input valid, input link_type, output ready);
endinterface

// ===== src/pte_in_stage.sv =====
// ----------------------------------------------------------------------------
// pte_in_stage
// input register for packet bytes
// ----------------------------------------------------------------------------
module pte_in_stage
    import pte_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    pte_byte_if.sink   pkt,
    input  logic       advance,
    output byte_item_t item
);

    logic       valid_reg;
    logic       valid_next;
    logic       last_reg;
    logic [7:0] data_reg;
    logic       take;

    // slot frees when its byte moves on
    assign pkt.ready = !valid_reg || advance;
    assign take      = pkt.valid && pkt.ready;

    always_comb
    begin
        valid_next = valid_reg;
        if (take)
        begin
            valid_next = 1'b1;
        end
        else if (advance)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            last_reg <= pkt.last;
            data_reg <= pkt.pkt_byte;
        end
    end

    assign item = '{valid: valid_reg, last: last_reg, data: data_reg};

endmodule

// ===== src/pte_capture.sv =====
// ----------------------------------------------------------------------------
// pte_capture
// per packet header state, updated by one byte each cycle while bytes advance
// ----------------------------------------------------------------------------
module pte_capture
    import pte_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic [1:0] link_type,
    input  byte_item_t item,
    input  logic       advance,
    output hdr_t       hdr_next
);

    hdr_t       hdr_reg;
    logic [7:0] idx;
    logic [7:0] b;
    logic [4:0] off;
    logic [7:0] off8;
    logic       eth;
    logic [7:0] r;
    logic [3:0] ver;
    logic [7:0] k;
    logic [7:0] l4;
    logic [7:0] j;

    assign idx = hdr_reg.byte_count;
    assign b   = item.data;
    assign ver = hdr_reg.version_ihl[7:4];

    always_comb
    begin
        hdr_next = hdr_reg;
        off      = hdr_reg.l3_offset;
        off8     = '0;
        eth      = 1'b0;
        r        = '0;
        k        = '0;
        l4       = '0;
        j        = '0;

        if (hdr_reg.byte_count != COUNT_MAX)
        begin
            hdr_next.byte_count = hdr_reg.byte_count + 8'd1;
        end

        if (idx < HDR_LIMIT)
        begin
            // framing is fixed by the link type seen on the first byte
            if (idx == 8'd0)
            begin
                case (link_type)
                    LINK_ETHERNET: off = ETH_L3_OFFSET;
                    LINK_NULL:     off = NULL_L3_OFFSET;
                    default:       off = RAW_L3_OFFSET;
                endcase
            end

            eth = (off == ETH_L3_OFFSET) || (off == VLAN_L3_OFFSET);
            if (eth)
            begin
                if (idx == ETH_TYPE_HI || idx == ETH_TYPE_LO ||
                    (off == VLAN_L3_OFFSET && (idx == VLAN_TYPE_HI || idx == VLAN_TYPE_LO)))
                begin
                    hdr_next.ether_type = {hdr_reg.ether_type[7:0], b};
                end
                // vlan tag pushes the ip header back by four bytes
                if (idx == ETH_TYPE_LO && hdr_next.ether_type == ETHERTYPE_VLAN)
                begin
                    off = VLAN_L3_OFFSET;
                end
            end
            hdr_next.l3_offset = off;
            off8 = {3'b000, off};

            if (idx >= off8)
            begin
                r = idx - off8;
                if (r == 8'd0)
                begin
                    hdr_next.version_ihl = b;
                end
                else if (ver == IP_VER4 || ver == IP_VER6)
                begin
                    if (ver == IP_VER4)
                    begin
                        if (r == IPV4_PROTO_POS)
                        begin
                            hdr_next.proto_byte = b;
                        end
                        else if (r >= IPV4_SRC_POS && r < IPV4_DST_POS)
                        begin
                            hdr_next.src_addr[{~r[1:0], 3'b000} +: 8] =
                                hdr_reg.src_addr[{~r[1:0], 3'b000} +: 8] | b;
                        end
                        else if (r >= IPV4_DST_POS && r < IPV4_ADDR_END)
                        begin
                            hdr_next.dst_addr[{~r[1:0], 3'b000} +: 8] =
                                hdr_reg.dst_addr[{~r[1:0], 3'b000} +: 8] | b;
                        end
                        l4 = off8 + {2'b00, hdr_reg.version_ihl[3:0], 2'b00};
                    end
                    else
                    begin
                        if (r == IPV6_NEXT_POS)
                        begin
                            hdr_next.proto_byte = b;
                        end
                        else if (r >= IPV6_SRC_POS && r < IPV6_DST_POS)
                        begin
                            k = r - IPV6_SRC_POS;
                            hdr_next.src_addr[{~k[3:0], 3'b000} +: 8] =
                                hdr_reg.src_addr[{~k[3:0], 3'b000} +: 8] | b;
                        end
                        else if (r >= IPV6_DST_POS && r < IPV6_ADDR_END)
                        begin
                            k = r - IPV6_DST_POS;
                            hdr_next.dst_addr[{~k[3:0], 3'b000} +: 8] =
                                hdr_reg.dst_addr[{~k[3:0], 3'b000} +: 8] | b;
                        end
                        l4 = off8 + IPV6_HDR_LEN;
                    end

                    // transport header: ports then tcp flags
                    if (idx >= l4)
                    begin
                        j = idx - l4;
                        if (j < PORT_BYTES)
                        begin
                            if (j[1])
                            begin
                                hdr_next.dst_port[{~j[0], 3'b000} +: 8] =
                                    hdr_reg.dst_port[{~j[0], 3'b000} +: 8] | b;
                            end
                            else
                            begin
                                hdr_next.src_port[{~j[0], 3'b000} +: 8] =
                                    hdr_reg.src_port[{~j[0], 3'b000} +: 8] | b;
                            end
                        end
                        else if (j == TCP_FLAGS_POS)
                        begin
                            hdr_next.tcp_flags = b;
                        end
                    end
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hdr_reg <= '0;
        end
        else if (advance)
        begin
            // state starts over after each last byte
            hdr_reg <= item.last ? '0 : hdr_next;
        end
    end

endmodule

// ===== src/pte_result.sv =====
// ----------------------------------------------------------------------------
// pte_result
// header checks and result register
// ----------------------------------------------------------------------------
module pte_result
    import pte_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  hdr_t        hdr,
    input  logic        load,
    pte_tuple_if.source tuple,
    output logic        res_free
);

    logic       valid_reg;
    logic       valid_next;
    tuple_t     res_reg;
    tuple_t     res_next;

    logic [7:0] c;
    logic [7:0] off8;
    logic [3:0] ver;
    logic [7:0] ihl_bytes;
    logic [7:0] avail;
    logic [7:0] l4;
    logic       eth;
    logic       et_ip;

    assign off8      = {3'b000, hdr.l3_offset};
    assign ver       = hdr.version_ihl[7:4];
    assign ihl_bytes = {2'b00, hdr.version_ihl[3:0], 2'b00};
    assign c         = (hdr.byte_count < HDR_LIMIT) ? hdr.byte_count : HDR_LIMIT;
    assign avail     = c - off8;
    assign l4        = off8 + ((ver == IP_VER6) ? IPV6_HDR_LEN : ihl_bytes);
    assign eth       = (hdr.l3_offset == ETH_L3_OFFSET) || (hdr.l3_offset == VLAN_L3_OFFSET);
    assign et_ip     = (hdr.ether_type == ETHERTYPE_IPV4) || (hdr.ether_type == ETHERTYPE_IPV6);

    always_comb
    begin
        res_next = '0;
        res_next.captured_length = hdr.byte_count;

        if (eth && (c < ETH_HDR_LEN || c < off8))
        begin
            res_next.status = ST_SHORT;
        end
        else if (eth && !et_ip)
        begin
            res_next.status = ST_NOT_IP;
        end
        else if (c <= off8)
        begin
            res_next.status = ST_SHORT;
        end
        else if (ver == IP_VER4)
        begin
            if (avail < IPV4_MIN_HDR)
            begin
                res_next.status = ST_SHORT;
            end
            else if (ihl_bytes < IPV4_MIN_HDR)
            begin
                res_next.status = ST_BAD_IHL;
            end
            else if (avail < ihl_bytes)
            begin
                res_next.status = ST_SHORT;
            end
            else
            begin
                res_next.status = ST_OK;
            end
        end
        else if (ver == IP_VER6)
        begin
            res_next.status = (avail < IPV6_HDR_LEN) ? ST_SHORT : ST_OK;
        end
        else
        begin
            res_next.status = ST_BAD_VER;
        end

        if (res_next.status == ST_OK)
        begin
            res_next.ip_version    = ver[2:0];
            res_next.ip_protocol   = hdr.proto_byte;
            res_next.src_addr_high = hdr.src_addr[127:64];
            res_next.src_addr_low  = hdr.src_addr[63:0];
            res_next.dst_addr_high = hdr.dst_addr[127:64];
            res_next.dst_addr_low  = hdr.dst_addr[63:0];
            if ((hdr.proto_byte == PROTO_TCP || hdr.proto_byte == PROTO_UDP) &&
                (l4 + PORT_BYTES <= c))
            begin
                res_next.src_port = hdr.src_port;
                res_next.dst_port = hdr.dst_port;
            end
            if (hdr.proto_byte == PROTO_TCP && (l4 + TCP_FLAGS_END <= c))
            begin
                res_next.pure_syn = ((hdr.tcp_flags & TCP_FLAG_SYN) != 8'd0) &&
                                    ((hdr.tcp_flags & TCP_FLAG_ACK) == 8'd0);
            end
        end
    end

    assign res_free = !valid_reg || tuple.ready;

    always_comb
    begin
        valid_next = valid_reg;
        if (load)
        begin
            valid_next = 1'b1;
        end
        else if (tuple.ready)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            res_reg <= res_next;
        end
    end

    assign tuple.valid           = valid_reg;
    assign tuple.status          = res_reg.status;
    assign tuple.ip_version      = res_reg.ip_version;
    assign tuple.ip_protocol     = res_reg.ip_protocol;
    assign tuple.src_addr_high   = res_reg.src_addr_high;
    assign tuple.src_addr_low    = res_reg.src_addr_low;
    assign tuple.dst_addr_high   = res_reg.dst_addr_high;
    assign tuple.dst_addr_low    = res_reg.dst_addr_low;
    assign tuple.src_port        = res_reg.src_port;
    assign tuple.dst_port        = res_reg.dst_port;
    assign tuple.pure_syn        = res_reg.pure_syn;
    assign tuple.captured_length = res_reg.captured_length;

endmodule

// ===== src/packet_header_tuple_extractor.sv =====
// ----------------------------------------------------------------------------
// packet_header_tuple_extractor
// streams packet bytes, captures ip and transport headers, emits one tuple
// ----------------------------------------------------------------------------
// throughput: one byte per cycle, set by the single capture update, while no last byte waits on a full result
// result path: a last byte is taken into the input register, then loaded into the result register
//   once that is free, which raises the tuple valid
// reset: clears link type to ethernet, capture state and both valid flags
// ----------------------------------------------------------------------------
module packet_header_tuple_extractor
    import pte_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    pte_byte_if.sink    pkt,
    pte_tuple_if.source tuple,
    pte_cfg_if.sink     cfg
);

    // link type register; the user must write it only while no packet is in flight, the block does not enforce this
    logic [1:0] link_type_reg;

    byte_item_t item;
    hdr_t       hdr_next;
    logic       res_free;
    logic       advance;
    logic       load;

    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            link_type_reg <= LINK_ETHERNET;
        end
        else if (cfg.valid)
        begin
            link_type_reg <= cfg.link_type;
        end
    end

    // a byte moves on unless it is a last byte and the result register is full;
    // plain bytes keep flowing while a finished result waits
    assign advance = item.valid && (!item.last || res_free);
    assign load    = advance && item.last;

    // input register
    pte_in_stage u_in_stage (
        .clk     (clk),
        .rst_n   (rst_n),
        .pkt     (pkt),
        .advance (advance),
        .item    (item)
    );

    // header capture state, next value includes the current byte
    pte_capture u_capture (
        .clk       (clk),
        .rst_n     (rst_n),
        .link_type (link_type_reg),
        .item      (item),
        .advance   (advance),
        .hdr_next  (hdr_next)
    );

    // checks on the final state of the packet, result register
    pte_result u_result (
        .clk      (clk),
        .rst_n    (rst_n),
        .hdr      (hdr_next),
        .load     (load),
        .tuple    (tuple),
        .res_free (res_free)
    );

endmodule
